// ----- hdl/vmi_pkg.sv -----
package vmi_pkg;

    // coordinate width and derived datapath widths
    localparam int COORD_BITS = 16;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SUM_W      = SQ_W + 1;
    localparam int ROOT_W     = COORD_BITS;

    // result field widths
    localparam int STRAIGHT_W = 16;
    localparam int ARC_W      = 17;
    localparam int MEAN_W     = 16;

    // arc scaling, floor(root * 157 / 100)
    localparam logic [7:0] ARC_NUM = 8'd157;
    localparam logic [6:0] ARC_DEN = 7'd100;

    // product width, quotient width and reciprocal of the denominator
    localparam int PROD_W  = ROOT_W + 8;
    localparam int QUOT_W  = PROD_W - 6;
    localparam int RECIP_W = PROD_W - 6;
    localparam logic [RECIP_W-1:0] ARC_RECIP = RECIP_W'((64'd1 << PROD_W) / 100);

    // pipeline depth: front end, one stage per root bit, scaling
    localparam int FRONT_STAGES = 3;
    localparam int SCALE_STAGES = 4;
    localparam int DEPTH        = FRONT_STAGES + ROOT_W + SCALE_STAGES;

endpackage

// ----- hdl/vmi_front.sv -----
module vmi_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic signed [vmi_pkg::COORD_BITS-1:0] dx,
    input  logic signed [vmi_pkg::COORD_BITS-1:0] dy,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output logic [vmi_pkg::SUM_W-1:0]           sum
);

    logic [2:0]                       vld_reg;
    logic [2:0]                       adv;
    logic [vmi_pkg::COORD_BITS-1:0]   ax_reg;
    logic [vmi_pkg::COORD_BITS-1:0]   ay_reg;
    logic [vmi_pkg::COORD_BITS-1:0]   ax_next;
    logic [vmi_pkg::COORD_BITS-1:0]   ay_next;
    logic [vmi_pkg::SQ_W-1:0]         sqx_reg;
    logic [vmi_pkg::SQ_W-1:0]         sqy_reg;
    logic [vmi_pkg::SQ_W-1:0]         sqx_next;
    logic [vmi_pkg::SQ_W-1:0]         sqy_next;
    logic [vmi_pkg::SUM_W-1:0]        sum_reg;
    logic [vmi_pkg::SUM_W-1:0]        sum_next;

    // a stage moves when it is empty or the one after it moves
    assign adv[2]   = !vld_reg[2] || dn_ready;
    assign adv[1]   = !vld_reg[1] || adv[2];
    assign adv[0]   = !vld_reg[0] || adv[1];
    assign up_ready = adv[0];

    // magnitude, the most negative value maps to 2^(n-1)
    assign ax_next = dx[vmi_pkg::COORD_BITS-1]
                   ? (~unsigned'(dx)) + vmi_pkg::COORD_BITS'(1) : unsigned'(dx);
    assign ay_next = dy[vmi_pkg::COORD_BITS-1]
                   ? (~unsigned'(dy)) + vmi_pkg::COORD_BITS'(1) : unsigned'(dy);

    assign sqx_next = vmi_pkg::SQ_W'(ax_reg) * vmi_pkg::SQ_W'(ax_reg);
    assign sqy_next = vmi_pkg::SQ_W'(ay_reg) * vmi_pkg::SQ_W'(ay_reg);
    assign sum_next = vmi_pkg::SUM_W'(sqx_reg) + vmi_pkg::SUM_W'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= up_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (adv[1])
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (adv[2])
        begin
            sum_reg <= sum_next;
        end
    end

    assign dn_valid = vld_reg[2];
    assign sum      = sum_reg;

endmodule

// ----- hdl/vmi_root.sv -----
module vmi_root
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic [vmi_pkg::SUM_W-1:0]    sum,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output logic [vmi_pkg::ROOT_W-1:0]   root
);

    localparam int N = vmi_pkg::ROOT_W;

    logic                        vld_reg  [N];
    logic                        adv      [N];
    logic [vmi_pkg::SUM_W-1:0]   rem_reg  [N-1];
    logic [N-1:0]                root_reg [N];

    // one result bit per stage, most significant first
    for (genvar s = 0; s < N; s++)
    begin : g_bit
        localparam int B = N - 1 - s;

        logic                        v_in;
        logic                        rdy_dn;
        logic [vmi_pkg::SUM_W-1:0]   rem_in;
        logic [N-1:0]                root_in;
        logic [vmi_pkg::SUM_W-1:0]   trial;
        logic                        take;
        logic [vmi_pkg::SUM_W-1:0]   rem_next;
        logic [N-1:0]                root_next;

        if (s == 0)
        begin : g_first
            assign v_in    = up_valid;
            assign rem_in  = sum;
            assign root_in = '0;
        end
        else
        begin : g_mid
            assign v_in    = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        if (s == N - 1)
        begin : g_tail
            assign rdy_dn = dn_ready;
        end
        else
        begin : g_link
            assign rdy_dn = adv[s+1];
        end

        assign adv[s] = !vld_reg[s] || rdy_dn;

        // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
        assign trial     = (vmi_pkg::SUM_W'(root_in) << (B + 1))
                         | (vmi_pkg::SUM_W'(1) << (2 * B));
        assign take      = trial <= rem_in;
        assign rem_next  = take ? rem_in - trial : rem_in;
        assign root_next = take ? root_in | (N'(1) << B) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv[s])
            begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                root_reg[s] <= root_next;
            end
        end

        // the last stage needs no remainder
        if (s < N - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    rem_reg[s] <= rem_next;
                end
            end
        end
    end

    assign up_ready = adv[0];
    assign dn_valid = vld_reg[N-1];
    assign root     = root_reg[N-1];

endmodule

// ----- hdl/vmi_scale.sv -----
module vmi_scale
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic [vmi_pkg::ROOT_W-1:0]        root,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [vmi_pkg::STRAIGHT_W-1:0]    straight_len,
    output logic [vmi_pkg::ARC_W-1:0]         arc_len,
    output logic [vmi_pkg::MEAN_W-1:0]        mean_len
);

    localparam int P  = vmi_pkg::PROD_W;
    localparam int Q  = vmi_pkg::QUOT_W;
    localparam int RW = vmi_pkg::RECIP_W;

    logic [3:0]                    vld_reg;
    logic [3:0]                    adv;
    logic [vmi_pkg::ROOT_W-1:0]    s_a_reg;
    logic [vmi_pkg::ROOT_W-1:0]    s_b_reg;
    logic [vmi_pkg::ROOT_W-1:0]    s_c_reg;
    logic [vmi_pkg::ROOT_W-1:0]    s_d_reg;
    logic [P-1:0]                  p_reg;
    logic [P-1:0]                  p_next;
    logic [P-1:0]                  p_b_reg;
    logic [Q-1:0]                  qe_reg;
    logic [Q-1:0]                  qe_next;
    logic [P+RW-1:0]               recip_prod;
    logic [P-1:0]                  resid;
    logic [Q-1:0]                  arc_reg;
    logic [Q-1:0]                  arc_next;
    logic [Q-1:0]                  arc_d_reg;
    logic [Q:0]                    mean_sum;
    logic [Q-1:0]                  mean_reg;

    assign adv[3]   = !vld_reg[3] || dn_ready;
    assign adv[2]   = !vld_reg[2] || adv[3];
    assign adv[1]   = !vld_reg[1] || adv[2];
    assign adv[0]   = !vld_reg[0] || adv[1];
    assign up_ready = adv[0];

    assign p_next = P'(root) * P'(vmi_pkg::ARC_NUM);

    // reciprocal estimate, low by at most one
    assign recip_prod = (P + RW)'(p_reg) * (P + RW)'(vmi_pkg::ARC_RECIP);
    assign qe_next    = recip_prod[P+Q-1:P];

    // one correction step
    assign resid    = p_b_reg - P'(qe_reg) * P'(vmi_pkg::ARC_DEN);
    assign arc_next = (resid >= P'(vmi_pkg::ARC_DEN)) ? qe_reg + Q'(1) : qe_reg;

    assign mean_sum = (Q + 1)'(s_c_reg) + (Q + 1)'(arc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= up_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
            if (adv[3])
            begin
                vld_reg[3] <= vld_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s_a_reg <= root;
            p_reg   <= p_next;
        end
        if (adv[1])
        begin
            s_b_reg <= s_a_reg;
            p_b_reg <= p_reg;
            qe_reg  <= qe_next;
        end
        if (adv[2])
        begin
            s_c_reg <= s_b_reg;
            arc_reg <= arc_next;
        end
        if (adv[3])
        begin
            s_d_reg   <= s_c_reg;
            arc_d_reg <= arc_reg;
            mean_reg  <= mean_sum[Q:1];
        end
    end

    assign dn_valid     = vld_reg[3];
    assign straight_len = vmi_pkg::STRAIGHT_W'(s_d_reg);
    assign arc_len      = vmi_pkg::ARC_W'(arc_d_reg);
    assign mean_len     = vmi_pkg::MEAN_W'(mean_reg);

endmodule

// ----- hdl/vector_magnitude_isqrt.sv -----
// path lengths of a signed coordinate offset
//
// request channel: dx, dy (two's complement) with coord_valid / coord_ready
// result channel: straight_len, arc_len, mean_len with len_valid / len_ready
// straight_len = floor sqrt(dx^2 + dy^2), arc_len = floor(157 * straight / 100),
// mean_len = floor((straight + arc) / 2)
//
// one request per cycle unless a held result stalls the pipeline; from
// acceptance to len_valid, magnitude, squares and sum take three stages, the
// root one stage per result bit (16), the arc scaling and mean four stages
// every stage holds a valid bit and moves when empty or when the stage after
// it moves, so bubbles close up and a full pipeline holds up to 23 requests
// when len_ready is low the last stage holds its result unchanged and the
// stall walks back stage by stage; coord_ready drops only once every stage
// is full
// reset clears all valid bits; no other state
module vector_magnitude_isqrt
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  coord_valid,
    output logic                                  coord_ready,
    input  logic signed [vmi_pkg::COORD_BITS-1:0] dx,
    input  logic signed [vmi_pkg::COORD_BITS-1:0] dy,
    output logic                                  len_valid,
    input  logic                                  len_ready,
    output logic [vmi_pkg::STRAIGHT_W-1:0]        straight_len,
    output logic [vmi_pkg::ARC_W-1:0]             arc_len,
    output logic [vmi_pkg::MEAN_W-1:0]            mean_len
);

    // front end to root
    logic                          sum_valid;
    logic                          sum_ready;
    logic [vmi_pkg::SUM_W-1:0]     sum;

    // root to scaling
    logic                          root_valid;
    logic                          root_ready;
    logic [vmi_pkg::ROOT_W-1:0]    root;

    // magnitudes, squares and their sum
    vmi_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (coord_valid),
        .up_ready (coord_ready),
        .dx       (dx),
        .dy       (dy),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .sum      (sum)
    );

    // restoring square root, one bit per stage
    vmi_root u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .sum      (sum),
        .dn_valid (root_valid),
        .dn_ready (root_ready),
        .root     (root)
    );

    // arc by reciprocal multiply with one correction, then the mean
    vmi_scale u_scale
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (root_valid),
        .up_ready     (root_ready),
        .root         (root),
        .dn_valid     (len_valid),
        .dn_ready     (len_ready),
        .straight_len (straight_len),
        .arc_len      (arc_len),
        .mean_len     (mean_len)
    );

    // back-pressure at the input only comes from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !coord_ready |-> (len_valid && !len_ready))
        else $error("request stalled without a held result");

    // the arc is never shorter than the straight line
    a_arc_order: assert property (@(posedge clk) disable iff (!rst_n)
        len_valid |-> (arc_len >= vmi_pkg::ARC_W'(straight_len)))
        else $error("arc length below straight length");

    // the mean travels with the same request as both lengths
    a_mean_match: assert property (@(posedge clk) disable iff (!rst_n)
        len_valid |-> (vmi_pkg::ARC_W'(mean_len) ==
            vmi_pkg::ARC_W'(((vmi_pkg::ARC_W + 1)'(straight_len)
                           + (vmi_pkg::ARC_W + 1)'(arc_len)) >> 1)))
        else $error("mean length out of step with its lengths");

endmodule
